### design/lfu_pkg.sv
// package for the lfu cache: sizes, codes, entry layout and sequencer states
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;
  localparam logic [DATA_W-1:0] COUNT_MAX  = '1;

  // register index on the configuration port
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } lfu_state_t;

endpackage

### design/lfu_cache_lookup_evict_top.sv
// lfu cache top level: entry memory, slot scan sequencer, update and result registers
//
// Each item walks the single read port of the entry memory over every slot, one a
// cycle, to find the key, the free slot and the eviction victim; then the finish
// state writes the touched or inserted entry back and the result is shown on the
// out_ ports for one cycle, marked by out_valid, while busy is already low. With
// capacity zero an item skips the walk and goes straight to the finish state. The
// receiver cannot stall results.
module lfu_cache_lookup_evict_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_cmd,
  input  logic signed [31:0]         in_key,
  input  logic signed [31:0]         in_value,
  output logic                       out_valid,
  output logic signed [31:0]         out_read_value,
  output logic                       out_hit,
  output logic                       out_evicted,
  output logic signed [31:0]         out_evicted_key,
  output logic                       out_status,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lfu_pkg::*;

  lfu_state_t state_r, state_nxt;

  logic [CAP_W-1:0]  cap_r;
  logic [DATA_W-1:0] cap_eff;
  logic              cap_zero;

  logic [DATA_W-1:0] tick_r;
  logic              ovf_r;
  logic [ENTRIES-1:0] valid_r;

  // captured item
  logic              op_cmd_r;
  logic [DATA_W-1:0] op_key_r;
  logic [DATA_W-1:0] op_value_r;

  // scan pipeline
  logic [OCC_W-1:0]  cnt_r;
  logic              rvalid_r;
  logic [IDX_W-1:0]  ridx_r;
  entry_t            rdata_r;
  entry_t            mem [ENTRIES];

  // scan results
  logic              match_found_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [DATA_W-1:0] match_val_r;
  logic [DATA_W-1:0] match_cnt_r;
  logic              free_found_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              vic_found_r;
  logic [IDX_W-1:0]  vic_idx_r;
  logic [DATA_W-1:0] vic_key_r;
  logic [DATA_W-1:0] vic_cnt_r;
  logic [DATA_W-1:0] vic_stamp_r;
  logic [OCC_W-1:0]  used_r;

  // sequencer controls
  logic accept;
  logic scan_issue;
  logic finishing;

  // update path
  logic              rd_valid_entry;
  logic              take_victim;
  logic              mem_we;
  logic [IDX_W-1:0]  waddr;
  entry_t            wdata;
  logic              advance;
  logic [DATA_W-1:0] tick_inc;
  logic              ovf_nxt;
  logic              evict;
  logic [DATA_W-1:0] res_value;
  logic              res_hit;

  assign cap_eff  = (DATA_W'(cap_r) > DATA_W'(ENTRIES)) ? DATA_W'(ENTRIES) : DATA_W'(cap_r);
  assign cap_zero = (cap_eff == '0);

  // configuration port
  assign pready = 1'b1;
  assign prdata = 32'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CAPACITY)) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = cap_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == OCC_W'(ENTRIES)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy       = 1'b1;
    scan_issue = 1'b0;
    finishing  = 1'b0;
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_SCAN: begin
        scan_issue = (cnt_r < OCC_W'(ENTRIES));
      end
      ST_FINISH: finishing = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd_r   <= in_cmd;
      op_key_r   <= in_key;
      op_value_r <= in_value;
    end
  end

  // address counter and read-data tag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rvalid_r <= 1'b0;
    end else begin
      rvalid_r <= scan_issue;
      if (accept) begin
        cnt_r <= '0;
      end else if (scan_issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx_r <= cnt_r[IDX_W-1:0];
  end

  // entry memory, one read and one write port
  always_ff @(posedge clk) begin
    rdata_r <= mem[cnt_r[IDX_W-1:0]];
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  assign rd_valid_entry = rvalid_r && valid_r[ridx_r];

  // lower count wins, then older stamp; ties keep the lower slot
  assign take_victim = !vic_found_r || (rdata_r.count < vic_cnt_r) ||
                       ((rdata_r.count == vic_cnt_r) && (rdata_r.stamp < vic_stamp_r));

  always_ff @(posedge clk) begin
    if (!rst_n || accept) begin
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
      vic_found_r   <= 1'b0;
      used_r        <= '0;
    end else if (rvalid_r) begin
      if (rd_valid_entry) begin
        used_r <= used_r + 1'b1;
        if (!match_found_r && (rdata_r.key == op_key_r)) begin
          match_found_r <= 1'b1;
        end
        if (take_victim) begin
          vic_found_r <= 1'b1;
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_entry) begin
      if (!match_found_r && (rdata_r.key == op_key_r)) begin
        match_idx_r <= ridx_r;
        match_val_r <= rdata_r.value;
        match_cnt_r <= rdata_r.count;
      end
      if (take_victim) begin
        vic_idx_r   <= ridx_r;
        vic_key_r   <= rdata_r.key;
        vic_cnt_r   <= rdata_r.count;
        vic_stamp_r <= rdata_r.stamp;
      end
    end else if (rvalid_r && !free_found_r) begin
      free_idx_r <= ridx_r;
    end
  end

  // write-back and result
  assign tick_inc = tick_r + 1'b1;

  always_comb begin
    mem_we    = 1'b0;
    waddr     = match_idx_r;
    wdata     = '{key: op_key_r, value: op_value_r, count: DATA_W'(1), stamp: tick_inc};
    advance   = 1'b0;
    evict     = 1'b0;
    res_hit   = 1'b0;
    res_value = '0;
    if (finishing) begin
      if (cap_zero) begin
        res_value = (op_cmd_r == CMD_GET) ? MISS_VALUE : '0;
      end else if (match_found_r) begin
        res_hit     = 1'b1;
        mem_we      = 1'b1;
        advance     = 1'b1;
        waddr       = match_idx_r;
        wdata.value = (op_cmd_r == CMD_PUT) ? op_value_r : match_val_r;
        wdata.count = (match_cnt_r == COUNT_MAX) ? match_cnt_r : match_cnt_r + 1'b1;
        res_value   = (op_cmd_r == CMD_GET) ? match_val_r : '0;
      end else if (op_cmd_r == CMD_GET) begin
        res_value = MISS_VALUE;
      end else begin
        evict   = (DATA_W'(used_r) >= cap_eff) && vic_found_r;
        waddr   = evict ? vic_idx_r : free_idx_r;
        mem_we  = evict || free_found_r;
        advance = mem_we;
      end
    end
  end

  assign ovf_nxt = ovf_r || (advance && (tick_inc == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= '0;
      ovf_r   <= 1'b0;
      valid_r <= '0;
    end else begin
      ovf_r <= ovf_nxt;
      if (advance) begin
        tick_r <= tick_inc;
      end
      if (mem_we) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= finishing;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      out_read_value  <= res_value;
      out_hit         <= res_hit;
      out_evicted     <= evict;
      out_evicted_key <= evict ? vic_key_r : '0;
      out_status      <= ovf_nxt;
    end
  end

endmodule

### design/lfu_checker.sv
// port-level checks for the lfu cache top level, bound to it
module lfu_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_hit,
  input logic               out_evicted,
  input logic signed [31:0] out_evicted_key,
  input logic               out_status
);

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low after item accepted");

  // a result lasts one cycle and is shown only once the block is free again
  a_result_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && !$past(out_valid))
    else $error("result strobe not a single cycle after the work");

  // an eviction only happens on a miss
  a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_hit)
    else $error("eviction reported with a hit");

  a_evict_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == 32'sd0))
    else $error("evicted key nonzero without eviction");

  // the overflow flag is sticky
  a_status_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |=> out_status)
    else $error("status flag dropped");

endmodule

bind lfu_cache_lookup_evict_top lfu_checker u_lfu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key),
  .out_status      (out_status)
);
